// ----- src/srp_pkg.sv -----
// shared types and constants for the s-record line parser
// no dependencies; imported by every module of the block
package srp_pkg;

    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_LF   = 8'h0A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_F    = 8'h46;

    localparam logic [7:0] POS_TYPE   = 8'd1;
    localparam logic [7:0] POS_ADDR0  = 8'd4;
    localparam logic [7:0] POS_SAT    = 8'd255;

    typedef enum logic [1:0] {
        KIND_ADDRESS = 2'd0,
        KIND_DATA    = 2'd1,
        KIND_END     = 2'd2
    } kind_t;

    typedef struct packed {
        logic       is_cr;
        logic       is_lf;
        logic [3:0] raw_nibble;
        logic [3:0] first_nibble;
        logic [3:0] second_nibble;
    } char_info_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [7:0]  data_byte;
        logic [3:0]  byte_index;
        logic [4:0]  byte_count;
        logic        overflow;
        logic [3:0]  record_type;
    } result_t;

endpackage

// ----- src/srp_char_decode.sv -----
// character classifier and hex nibble decoder
// depends on srp_pkg
module srp_char_decode (
    input  logic [7:0]          character,
    output srp_pkg::char_info_t info
);
    import srp_pkg::*;

    logic is_dec;
    logic is_hex_letter;

    always_comb begin
        is_dec        = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
        is_hex_letter = (character >= CHAR_A) && (character <= CHAR_F);
        info.is_cr      = (character == CHAR_CR);
        info.is_lf      = (character == CHAR_LF);
        info.raw_nibble = character[3:0];
        // letters: low nibble plus 9 gives 10..15 for a..f, wraps for others
        info.first_nibble  = is_dec ? character[3:0] : character[3:0] + 4'd9;
        info.second_nibble = is_hex_letter ? character[3:0] + 4'd9 : character[3:0];
    end

endmodule

// ----- src/srp_line_state.sv -----
// per-line parser state and next-result logic
// depends on srp_pkg
module srp_line_state #(
    parameter int MAX_DATA = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  srp_pkg::char_info_t info,
    output logic                emit,
    output srp_pkg::result_t    result
);
    import srp_pkg::*;

    localparam int DCW = $clog2(MAX_DATA + 1);

    logic [7:0]     pos_reg,      pos_next;
    logic [3:0]     type_reg,     type_next;
    logic [31:0]    addr_reg,     addr_next;
    logic [3:0]     hi_reg,       hi_next;
    logic [7:0]     held_reg,     held_next;
    logic           held_vld_reg, held_vld_next;
    logic [DCW-1:0] dc_reg,       dc_next;
    logic           ovf_reg,      ovf_next;

    logic [7:0]     rel;
    logic [5:0]     addr_chars;
    logic [7:0]     value;
    logic [DCW+4:0] idx_wide;
    logic [DCW+4:0] cnt_wide;

    always_comb begin
        pos_next      = pos_reg;
        type_next     = type_reg;
        addr_next     = addr_reg;
        hi_next       = hi_reg;
        held_next     = held_reg;
        held_vld_next = held_vld_reg;
        dc_next       = dc_reg;
        ovf_next      = ovf_reg;
        emit          = 1'b0;
        rel           = pos_reg - POS_ADDR0;
        addr_chars    = {5'({1'b0, type_reg} + 5'd1), 1'b0};
        value         = {hi_reg, info.second_nibble};
        idx_wide      = (DCW+5)'(dc_reg);
        result.kind        = KIND_END;
        result.data_byte   = 8'd0;
        result.byte_index  = 4'd0;

        if (info.is_cr) begin
            emit = 1'b1;
        end else if (!info.is_lf && pos_reg != POS_SAT) begin
            pos_next = pos_reg + 8'd1;
            if (pos_reg == POS_TYPE) begin
                type_next = info.raw_nibble;
            end else if (pos_reg >= POS_ADDR0) begin
                if (!rel[0]) begin
                    hi_next = info.first_nibble;
                end else if (rel < 8'(addr_chars)) begin
                    addr_next = {addr_reg[23:0], value};
                    if (rel == 8'(addr_chars - 6'd1)) begin
                        emit        = 1'b1;
                        result.kind = KIND_ADDRESS;
                    end
                end else begin
                    if (held_vld_reg) begin
                        if (dc_reg < DCW'(MAX_DATA)) begin
                            dc_next           = dc_reg + DCW'(1);
                            emit              = 1'b1;
                            result.kind       = KIND_DATA;
                            result.data_byte  = held_reg;
                            result.byte_index = idx_wide[3:0];
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    held_next     = value;
                    held_vld_next = 1'b1;
                end
            end
        end

        // end-of-record shows the state as it stands before the clear
        cnt_wide           = (DCW+5)'(dc_next);
        result.address     = addr_next;
        result.byte_count  = cnt_wide[4:0];
        result.overflow    = ovf_next;
        result.record_type = type_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && info.is_cr)) begin
            pos_reg      <= '0;
            type_reg     <= '0;
            addr_reg     <= '0;
            hi_reg       <= '0;
            held_reg     <= '0;
            held_vld_reg <= 1'b0;
            dc_reg       <= '0;
            ovf_reg      <= 1'b0;
        end else if (accept) begin
            pos_reg      <= pos_next;
            type_reg     <= type_next;
            addr_reg     <= addr_next;
            hi_reg       <= hi_next;
            held_reg     <= held_next;
            held_vld_reg <= held_vld_next;
            dc_reg       <= dc_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

// ----- src/srecord_line_parser_unit.sv -----
// top level of the s-record line parser: stream ports and result register
// depends on srp_pkg, srp_char_decode and srp_line_state
//
// takes one ascii character of a motorola s-record line per transaction and
// returns zero or one result per character. the second character gives the
// type digit and the address length (digit plus 1 bytes); the count field is
// skipped. an address result (kind 0) comes out when the last address pair
// arrives; each later hex pair is a data byte that is released one pair late
// (kind 1), so the final pair, the checksum, never comes out and is not
// checked. a carriage return gives an end-of-record result (kind 2) with the
// address, byte count and overflow flag, then clears the line state; a
// newline is ignored. data bytes past MAX_DATA are dropped and set the
// overflow flag until the end of the line. decode and state update are a
// single combinational pass into the result register, and a character is
// taken whenever that register is empty or being drained in the same
// cycle, so full throughput is one per clock.
module srecord_line_parser_unit #(
    parameter int MAX_DATA = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // address, data_byte, byte_index, byte_count,
                                   // overflow, record_type, zero pad
    output logic [1:0]  m_tuser    // [1:0] kind
);
    import srp_pkg::*;

    char_info_t info;
    result_t    result;
    logic       emit;
    logic       accept;

    result_t    out_reg;
    logic       out_vld_reg;

    // the result register frees up in the same cycle it is drained
    assign s_tready = !out_vld_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    srp_char_decode u_decode (
        .character (s_tdata),
        .info      (info)
    );

    srp_line_state #(
        .MAX_DATA (MAX_DATA)
    ) u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .info    (info),
        .emit    (emit),
        .result  (result)
    );

    // valid flag of the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (accept) begin
            out_vld_reg <= emit;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    // result payload, loaded only when a character produces a result
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {2'b00,
                       out_reg.record_type,
                       out_reg.overflow,
                       out_reg.byte_count,
                       out_reg.byte_index,
                       out_reg.data_byte,
                       out_reg.address};

endmodule

// ----- dv/srecord_line_parser_unit_test.sv -----
// self-checking testbench for srecord_line_parser_unit: streams s-record characters
// through the block and compares every result against an in-bench line parser
// depends on srp_pkg and the rtl of the block; reads no files
module srecord_line_parser_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srp_pkg::*;

    localparam int MAX_DATA   = 16;
    localparam int RAND_ITEMS = 500;
    localparam int LONG_HOLD  = 200;   // one long receiver stall, in cycles
    localparam int SETTLE     = 4;     // settle time after the last result; the block has one result register
    localparam int LONG_LINE  = 5;     // record number that gets the over-long line

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SLOW,
        RX_TOGGLE
    } rx_mode_t;

    // one row of the directed part: a character and, where obvious, its result
    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        result_t    want;
    } dir_row_t;

    localparam result_t NO_RESULT = '0;
    localparam int DIR_LEN = 24;

    localparam dir_row_t DIR_ROWS [DIR_LEN] = '{
        // carriage return straight after reset: end record with everything zero
        '{CHAR_CR, 1'b1, '{KIND_END, 32'h0, 8'h00, 4'h0, 5'd0, 1'b0, 4'h0}},
        // s3 line, 4-byte address of all ones
        '{"S", 1'b0, NO_RESULT},
        '{"3", 1'b0, NO_RESULT},
        '{"0", 1'b0, NO_RESULT},
        '{"5", 1'b0, NO_RESULT},
        '{CHAR_F, 1'b0, NO_RESULT},
        '{CHAR_F, 1'b0, NO_RESULT},
        '{CHAR_F, 1'b0, NO_RESULT},
        '{CHAR_F, 1'b0, NO_RESULT},
        '{CHAR_F, 1'b0, NO_RESULT},
        '{CHAR_F, 1'b0, NO_RESULT},
        '{CHAR_F, 1'b0, NO_RESULT},
        '{CHAR_F, 1'b1, '{KIND_ADDRESS, 32'hFFFF_FFFF, 8'h00, 4'h0, 5'd0, 1'b0, 4'h3}},
        // data pair, a newline in the middle of the line, then non-hex characters
        '{"0", 1'b0, NO_RESULT},
        '{"0", 1'b0, NO_RESULT},
        '{CHAR_LF, 1'b0, NO_RESULT},
        '{"a", 1'b0, NO_RESULT},
        '{"z", 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{CHAR_CR, 1'b0, NO_RESULT},
        // line cut short after the type digit
        '{"S", 1'b0, NO_RESULT},
        '{"9", 1'b0, NO_RESULT},
        '{CHAR_CR, 1'b1, '{KIND_END, 32'h0, 8'h00, 4'h0, 5'd0, 1'b0, 4'h9}}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    // line parser state mirrored in the bench
    logic [7:0]  line_pos;
    logic [3:0]  rec_type;
    logic [31:0] addr_acc;
    logic [3:0]  hi_nib;
    logic [7:0]  held;
    logic        held_vld;
    logic [4:0]  byte_cnt;
    logic        ovf_flag;

    result_t     parsed_q [$];     // results still owed by the block
    int          errors       = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          kind_seen [3] = '{0, 0, 0};
    int          ovf_lines    = 0;
    int          burst_left   = 0;
    bit          rx_holding   = 1'b0;
    bit          hold_done    = 1'b0;

    srecord_line_parser_unit #(
        .MAX_DATA (MAX_DATA)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // line parser model
    // ---------------------------------------------------------------

    function automatic void clear_line();
        line_pos = '0;
        rec_type = '0;
        addr_acc = '0;
        hi_nib   = '0;
        held     = '0;
        held_vld = 1'b0;
        byte_cnt = '0;
        ovf_flag = 1'b0;
    endfunction

    // first character of a pair: digits first, everything else as a letter
    function automatic logic [3:0] hi_digit(input logic [7:0] c);
        logic [7:0] t;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            t = c - CHAR_ZERO;
        else
            t = c - CHAR_A + 8'd10;
        return t[3:0];
    endfunction

    // second character of a pair: letters first, everything else as a digit
    function automatic logic [3:0] lo_digit(input logic [7:0] c);
        logic [7:0] t;
        if (c >= CHAR_A && c <= CHAR_F)
            t = c - CHAR_A + 8'd10;
        else
            t = c - CHAR_ZERO;
        return t[3:0];
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [7:0] b,
                                            input logic [3:0] idx);
        result_t r;
        r.kind        = k;
        r.address     = addr_acc;
        r.data_byte   = b;
        r.byte_index  = idx;
        r.byte_count  = byte_cnt;
        r.overflow    = ovf_flag;
        r.record_type = rec_type;
        return r;
    endfunction

    // advances the line state by one character; returns 1 when a result is due
    function automatic bit parse_char(input logic [7:0] c, output result_t r);
        logic [7:0] p;
        logic [7:0] rel;
        logic [7:0] span;
        logic [7:0] val;
        logic [7:0] t;
        logic [4:0] idx;
        bit         produced;
        produced = 1'b0;
        r = NO_RESULT;
        if (c == CHAR_CR) begin
            // end of record reports the line as it stands, then starts over
            r = make_result(KIND_END, 8'h00, 4'h0);
            produced = 1'b1;
            clear_line();
        end else if (c != CHAR_LF && line_pos != POS_SAT) begin
            p = line_pos;
            line_pos = p + 8'd1;
            if (p == POS_TYPE) begin
                t = c - CHAR_ZERO;
                rec_type = t[3:0];
            end else if (p >= POS_ADDR0) begin
                rel  = p - POS_ADDR0;
                span = 8'(2 * (rec_type + 1));
                if (!rel[0]) begin
                    hi_nib = hi_digit(c);
                end else begin
                    val = {hi_nib, lo_digit(c)};
                    if (rel < span) begin
                        addr_acc = {addr_acc[23:0], val};
                        if (rel == span - 8'd1) begin
                            r = make_result(KIND_ADDRESS, 8'h00, 4'h0);
                            produced = 1'b1;
                        end
                    end else begin
                        // data goes out one pair late so the checksum never does
                        if (held_vld) begin
                            if (byte_cnt < MAX_DATA) begin
                                idx = byte_cnt;
                                byte_cnt = idx + 5'd1;
                                r = make_result(KIND_DATA, held, idx[3:0]);
                                produced = 1'b1;
                            end else begin
                                ovf_flag = 1'b1;
                            end
                        end
                        held     = val;
                        held_vld = 1'b1;
                    end
                end
            end
        end
        return produced;
    endfunction

    // ---------------------------------------------------------------
    // input side
    // ---------------------------------------------------------------

    // sends one character in bursts with random gaps between them; where
    // typed is set the row's result stands in for the predicted one
    task automatic send_char(input logic [7:0] c, input logic typed, input result_t want);
        result_t r;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            // no gaps while the receiver is holding off, so the block backs up
            if (!rx_holding && $urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do @(posedge aclk); while (!s_tready);
        // newlines and characters past saturation are not real items
        if (c != CHAR_LF && (c == CHAR_CR || line_pos != POS_SAT))
            items_sent++;
        if (parse_char(c, r))
            parsed_q.push_back(typed ? want : r);
    endtask

    // stop sending until every result owed has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (parsed_q.size() != 0) @(posedge aclk);
    endtask

    // mostly proper hex digits, sometimes any byte at all
    function automatic logic [7:0] hex_char();
        string digits;
        digits = "0123456789ABCDEF";
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return digits[$urandom_range(0, 15)];
    endfunction

    // one record line with random content: well formed most of the time,
    // sometimes pure noise, cut short or missing its carriage return
    task automatic send_record(input bit very_long);
        logic [7:0]  line_q [$];
        logic [7:0]  tch;
        int unsigned shape;
        int unsigned n_pairs;
        int unsigned n_cut;
        shape = very_long ? 3 : $urandom_range(0, 19);
        if (shape == 0) begin
            repeat ($urandom_range(1, 10)) line_q.push_back(8'($urandom));
        end else begin
            line_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'("S"));
            tch = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                              : CHAR_ZERO + 8'($urandom_range(0, 9));
            line_q.push_back(tch);
            tch = tch - CHAR_ZERO;
            // count pair, address pairs, data pairs, checksum pair
            n_pairs = 1 + (tch[3:0] + 1) + $urandom_range(0, MAX_DATA + 4) + 1;
            if (very_long)
                n_pairs = 150;
            repeat (2 * n_pairs) line_q.push_back(hex_char());
            if ($urandom_range(0, 7) == 0)
                line_q.push_back(hex_char());   // lone trailing digit
            if (shape == 1) begin
                n_cut = $urandom_range(1, line_q.size() - 1);
                repeat (n_cut) void'(line_q.pop_back());
            end
            if (shape != 2)
                line_q.push_back(CHAR_CR);
            if ($urandom_range(0, 1) == 0)
                line_q.push_back(CHAR_LF);
        end
        foreach (line_q[i])
            send_char(line_q[i], 1'b0, NO_RESULT);
    endtask

    initial begin : stimulus
        int rec;
        bit paused;
        rec = 0;
        paused = 1'b0;
        clear_line();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[i])
            send_char(DIR_ROWS[i].ch, DIR_ROWS[i].typed, DIR_ROWS[i].want);
        drain_results();

        while (items_sent < DIR_LEN + RAND_ITEMS) begin
            send_record(rec == LONG_LINE);
            rec++;
            if (!paused && items_sent >= DIR_LEN + RAND_ITEMS / 2) begin
                drain_results();
                paused = 1'b1;
            end
        end
        s_tvalid <= 1'b0;

        while (parsed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("run covered %0d characters in %0d records: %0d address, %0d data results",
                 items_sent, kind_seen[KIND_END], kind_seen[KIND_ADDRESS],
                 kind_seen[KIND_DATA]);
        $display("%0d records ended with dropped data bytes", ovf_lines);
        if (errors == 0 && parsed_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // ---------------------------------------------------------------
    // output side
    // ---------------------------------------------------------------

    // stall patterns change at random intervals; one long hold-off lets
    // the result register fill and push back on the input
    initial begin : receiver
        rx_mode_t    mode;
        int unsigned left;
        mode = RX_OPEN;
        left = 0;
        forever begin
            @(posedge aclk);
            if (!hold_done && results_seen >= 80) begin
                hold_done  = 1'b1;
                rx_holding = 1'b1;
                m_tready  <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
                rx_holding = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(8, 64);
                end
                left--;
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                    RX_SLOW:   m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= ~m_tready;
                endcase
            end
        end
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            errors++;
        end
    endtask

    // compare every result transaction with the oldest one owed
    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            // m_tdata: address, data_byte, byte_index, byte_count, overflow, record_type
            got.kind        = kind_t'(m_tuser);
            got.address     = m_tdata[31:0];
            got.data_byte   = m_tdata[39:32];
            got.byte_index  = m_tdata[43:40];
            got.byte_count  = m_tdata[48:44];
            got.overflow    = m_tdata[49];
            got.record_type = m_tdata[53:50];
            results_seen++;
            if (m_tuser <= 2'd2)
                kind_seen[m_tuser]++;
            if (got.kind == KIND_END && got.overflow)
                ovf_lines++;
            if (parsed_q.size() == 0) begin
                $display({"%0t ns: result with nothing owed, expected none, ",
                          "actual kind %0d addr 0x%08h"},
                         $time, m_tuser, got.address);
                errors++;
            end else begin
                want = parsed_q.pop_front();
                check_field("kind", want.kind, got.kind);
                check_field("address", want.address, got.address);
                check_field("data_byte", want.data_byte, got.data_byte);
                check_field("byte_index", want.byte_index, got.byte_index);
                check_field("byte_count", want.byte_count, got.byte_count);
                check_field("overflow", want.overflow, got.overflow);
                check_field("record_type", want.record_type, got.record_type);
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial begin : watchdog
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
src/srp_pkg.sv
src/srp_char_decode.sv
src/srp_line_state.sv
src/srecord_line_parser_unit.sv
dv/srecord_line_parser_unit_test.sv
